// ===== hw/rtl/stvf_pkg.sv =====
package stvf_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_WT  = 2'd0,
    ACT_LOAD_SMP = 2'd1,
    ACT_RUN      = 2'd2,
    ACT_READ     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2,
    CFG_SKIP_Y = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_WRITE
  } state_e;

  // stencil form of the current point
  typedef enum logic [1:0] {
    FORM_COPY,
    FORM_FIRST,
    FORM_LAST2,
    FORM_MID
  } form_e;

  // slave tdata layout, lowest bit first
  localparam int unsigned IN_DW    = 112;
  localparam int unsigned AX_LSB   = 0;
  localparam int unsigned TI_LSB   = 2;
  localparam int unsigned WL_LSB   = 7;
  localparam int unsigned WC_LSB   = 25;
  localparam int unsigned WU_LSB   = 43;
  localparam int unsigned PX_LSB   = 61;
  localparam int unsigned PY_LSB   = 66;
  localparam int unsigned PZ_LSB   = 71;
  localparam int unsigned SMP_LSB  = 76;

  localparam int unsigned WT_W     = 18;
  localparam int unsigned SMP_W    = 32;
  localparam int unsigned PROD_W   = SMP_W + WT_W;
  localparam int unsigned RND_W    = PROD_W - 16;
  localparam int unsigned ACC_W    = RND_W + 2;
  localparam logic signed [WT_W-1:0] HALF_Q216 = 18'sd32768;

  // round half up to Q16.16
  function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return t[PROD_W-1:16];
  endfunction

  function automatic logic [SMP_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
    if (a > ACC_W'(64'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
    if (a < -ACC_W'(64'sh8000_0000)) return 32'h8000_0000;
    return a[SMP_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/stvf_ram.sv =====
module stvf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/separable_three_tap_volume_filter.sv =====
// Separable three-tap volume filter.
// Slave request channel (s_axis_*): tuser carries the action, tdata the
// weight triple, table index, coordinates and sample. Weight and sample
// loads return an all-zero response. A read returns the filtered sample
// from volume A, via the ST_READ state and the response register, with
// out_valid set (value 0 outside the current sizes). A run walks the
// volume three times (x, y, z) through one shared 32x18 multiplier and
// one read port per volume memory; each point runs read, multiply and
// accumulate for each of its three taps and then a write, copied points
// only a read and a write, and a run ends with run_done set.
// One request is in flight at a time: tready is high only when the
// sequencer is idle and the response register is empty. A stalled master
// side holds the response and blocks new requests.
// Configuration writes (sizes, skip_y_pass) are registered; issue them
// only while idle. Sizes below 4 act as 4, above the maximum as the maximum.
// Reset clears the control and configuration registers; weight and volume
// memories are not cleared and must be loaded before use.
module separable_three_tap_volume_filter #(
  parameter int unsigned MAX_X = 32,
  parameter int unsigned MAX_Y = 32,
  parameter int unsigned MAX_Z = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // axis, table_index, weight_lower, weight_center, weight_upper,
  // pos_x, pos_y, pos_z, sample, zero pad
  input  logic [111:0] s_axis_tdata_i,
  // action
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_value
  output logic [31:0] m_axis_tdata_o,
  // out_valid, run_done
  output logic [1:0]  m_axis_tuser_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_data_i
);
  import stvf_pkg::*;

  localparam int unsigned MaxXY  = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
  localparam int unsigned MaxM   = (MaxXY > MAX_Z) ? MaxXY : MAX_Z;
  localparam int unsigned PW     = $clog2(MaxM + 1);
  localparam int unsigned WtD    = MAX_X + MAX_Y + MAX_Z;
  localparam int unsigned WAW    = $clog2(WtD);
  localparam int unsigned VolD   = MAX_X * MAX_Y * MAX_Z;
  localparam int unsigned VAW    = $clog2(VolD);

  function automatic logic [VAW-1:0] vidx(input logic [PW-1:0] x, input logic [PW-1:0] y,
                                          input logic [PW-1:0] z);
    return VAW'((32'(z) * MAX_Y + 32'(y)) * MAX_X + 32'(x));
  endfunction

  // Configuration registers
  logic [5:0] size_x_q, size_y_q, size_z_q;
  logic       skip_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 6'd32;
      size_y_q <= 6'd32;
      size_z_q <= 6'd32;
      skip_y_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIZE_X: size_x_q <= cfg_data_i;
        CFG_SIZE_Y: size_y_q <= cfg_data_i;
        CFG_SIZE_Z: size_z_q <= cfg_data_i;
        CFG_SKIP_Y: skip_y_q <= cfg_data_i[0];
        default:    skip_y_q <= skip_y_q;
      endcase
    end
  end

  // Clamp sizes to [4, MAX]
  logic [PW-1:0] sx, sy, sz;
  always_comb begin
    sx = (size_x_q < 6'd4) ? PW'(4) : (32'(size_x_q) > MAX_X) ? PW'(MAX_X) : PW'(size_x_q);
    sy = (size_y_q < 6'd4) ? PW'(4) : (32'(size_y_q) > MAX_Y) ? PW'(MAX_Y) : PW'(size_y_q);
    sz = (size_z_q < 6'd4) ? PW'(4) : (32'(size_z_q) > MAX_Z) ? PW'(MAX_Z) : PW'(size_z_q);
  end

  // Request fields
  action_e            in_act;
  logic [1:0]         in_axis;
  logic [4:0]         in_ti, in_px, in_py, in_pz;
  logic [WT_W-1:0]    in_wl, in_wc, in_wu;
  logic [SMP_W-1:0]   in_smp;
  assign in_act  = action_e'(s_axis_tuser_i);
  assign in_axis = s_axis_tdata_i[AX_LSB +: 2];
  assign in_ti   = s_axis_tdata_i[TI_LSB +: 5];
  assign in_wl   = s_axis_tdata_i[WL_LSB +: WT_W];
  assign in_wc   = s_axis_tdata_i[WC_LSB +: WT_W];
  assign in_wu   = s_axis_tdata_i[WU_LSB +: WT_W];
  assign in_px   = s_axis_tdata_i[PX_LSB +: 5];
  assign in_py   = s_axis_tdata_i[PY_LSB +: 5];
  assign in_pz   = s_axis_tdata_i[PZ_LSB +: 5];
  assign in_smp  = s_axis_tdata_i[SMP_LSB +: SMP_W];

  // Sequencer state
  state_e                   state_q, state_d;
  axis_e                    pass_q, pass_d;
  logic [PW-1:0]            x_q, x_d, y_q, y_d, z_q, z_d;
  logic [1:0]               tap_q, tap_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     rd_in_q, rd_in_d;
  logic                     out_vld_q, out_vld_d;
  logic [SMP_W-1:0]         out_val_q, out_val_d;
  logic [1:0]               out_usr_q, out_usr_d;

  logic in_acc;
  assign s_axis_tready_o = (state_q == ST_IDLE) && !out_vld_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Point geometry along the current pass
  logic [PW-1:0] p, n, tap_p, tx, ty, tz;
  form_e         form;
  logic signed [2:0]      tap_off;
  logic signed [WT_W-1:0] tap_w;
  logic [WT_W-1:0]        wl_rd, wc_rd, wu_rd;
  logic [WAW-1:0]         wt_base;

  always_comb begin
    case (pass_q)
      AXIS_X:  begin p = x_q; n = sx; wt_base = '0; end
      AXIS_Y:  begin p = y_q; n = sy; wt_base = WAW'(MAX_X); end
      default: begin p = z_q; n = sz; wt_base = WAW'(MAX_X + MAX_Y); end
    endcase
    if (p == n - PW'(1) || (pass_q == AXIS_Y && skip_y_q)) form = FORM_COPY;
    else if (p == '0)                                      form = FORM_FIRST;
    else if (pass_q == AXIS_Y && p == n - PW'(2))          form = FORM_LAST2;
    else                                                   form = FORM_MID;

    tap_off = 3'sd0;
    tap_w   = $signed(wc_rd);
    case (form)
      FORM_FIRST: begin
        case (tap_q)
          2'd0:    begin tap_off = 3'sd0; tap_w = $signed(wc_rd); end
          2'd1:    begin tap_off = 3'sd1; tap_w = $signed(wu_rd); end
          default: begin tap_off = 3'sd2; tap_w = $signed(wl_rd); end
        endcase
      end
      FORM_LAST2, FORM_MID: begin
        case (tap_q)
          2'd0:    begin tap_off = -3'sd1; tap_w = $signed(wl_rd); end
          2'd1:    begin tap_off = 3'sd0;  tap_w = HALF_Q216; end
          default: begin
            tap_off = (form == FORM_LAST2) ? -3'sd2 : 3'sd1;
            tap_w   = $signed(wu_rd);
          end
        endcase
      end
      default: begin tap_off = 3'sd0; tap_w = $signed(wc_rd); end
    endcase

    tap_p = p + PW'(tap_off);
    tx = x_q; ty = y_q; tz = z_q;
    case (pass_q)
      AXIS_X:  tx = tap_p;
      AXIS_Y:  ty = tap_p;
      default: tz = tap_p;
    endcase
  end

  // Weight memories, one row per axis index
  logic           wt_we;
  logic [WAW-1:0] wt_waddr, wt_raddr;
  logic           wt_ok;

  always_comb begin
    wt_ok    = 1'b0;
    wt_waddr = '0;
    case (in_axis)
      AXIS_X:  begin wt_ok = 32'(in_ti) < MAX_X; wt_waddr = WAW'(in_ti); end
      AXIS_Y:  begin wt_ok = 32'(in_ti) < MAX_Y; wt_waddr = WAW'(MAX_X + 32'(in_ti)); end
      AXIS_Z:  begin
        wt_ok    = 32'(in_ti) < MAX_Z;
        wt_waddr = WAW'(MAX_X + MAX_Y + 32'(in_ti));
      end
      default: wt_ok = 1'b0;
    endcase
  end
  assign wt_we    = in_acc && in_act == ACT_LOAD_WT && wt_ok;
  assign wt_raddr = wt_base + WAW'(p);

  stvf_ram #(.Width(WT_W), .Depth(WtD)) u_wl (
    .clk_i, .we_i(wt_we), .waddr_i(wt_waddr), .wdata_i(in_wl),
    .raddr_i(wt_raddr), .rdata_o(wl_rd));
  stvf_ram #(.Width(WT_W), .Depth(WtD)) u_wc (
    .clk_i, .we_i(wt_we), .waddr_i(wt_waddr), .wdata_i(in_wc),
    .raddr_i(wt_raddr), .rdata_o(wc_rd));
  stvf_ram #(.Width(WT_W), .Depth(WtD)) u_wu (
    .clk_i, .we_i(wt_we), .waddr_i(wt_waddr), .wdata_i(in_wu),
    .raddr_i(wt_raddr), .rdata_o(wu_rd));

  // Volume memories: source -> A (x), A -> B (y), B -> A (z)
  logic [VAW-1:0]   pos_addr, tap_addr, cur_addr, a_raddr;
  logic             src_we, a_we, b_we;
  logic [SMP_W-1:0] src_rd, a_rd, b_rd, vol_rd, wr_val;
  logic             smp_ok;

  assign pos_addr = vidx(PW'(in_px), PW'(in_py), PW'(in_pz));
  assign tap_addr = vidx(tx, ty, tz);
  assign cur_addr = vidx(x_q, y_q, z_q);
  assign smp_ok   = 32'(in_px) < MAX_X && 32'(in_py) < MAX_Y && 32'(in_pz) < MAX_Z;
  assign src_we   = in_acc && in_act == ACT_LOAD_SMP && smp_ok;
  assign a_raddr  = (state_q == ST_IDLE) ? pos_addr : tap_addr;
  assign a_we     = state_q == ST_WRITE && pass_q != AXIS_Y;
  assign b_we     = state_q == ST_WRITE && pass_q == AXIS_Y;
  assign wr_val   = (form == FORM_COPY) ? vol_rd : sat32(acc_q);

  always_comb begin
    case (pass_q)
      AXIS_X:  vol_rd = src_rd;
      AXIS_Y:  vol_rd = a_rd;
      default: vol_rd = b_rd;
    endcase
  end

  stvf_ram #(.Width(SMP_W), .Depth(VolD)) u_src (
    .clk_i, .we_i(src_we), .waddr_i(pos_addr), .wdata_i(in_smp),
    .raddr_i(tap_addr), .rdata_o(src_rd));
  stvf_ram #(.Width(SMP_W), .Depth(VolD)) u_vol_a (
    .clk_i, .we_i(a_we), .waddr_i(cur_addr), .wdata_i(wr_val),
    .raddr_i(a_raddr), .rdata_o(a_rd));
  stvf_ram #(.Width(SMP_W), .Depth(VolD)) u_vol_b (
    .clk_i, .we_i(b_we), .waddr_i(cur_addr), .wdata_i(wr_val),
    .raddr_i(tap_addr), .rdata_o(b_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pass_q    <= AXIS_X;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      tap_q     <= '0;
      rd_in_q   <= 1'b0;
      out_vld_q <= 1'b0;
      out_usr_q <= '0;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
      tap_q     <= tap_d;
      rd_in_q   <= rd_in_d;
      out_vld_q <= out_vld_d;
      out_usr_q <= out_usr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    out_val_q <= out_val_d;
  end

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    tap_d     = tap_q;
    rd_in_d   = rd_in_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    out_val_d = out_val_q;
    out_usr_d = out_usr_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_act)
            ACT_RUN: begin
              state_d = ST_RD;
              pass_d  = AXIS_X;
              x_d     = '0;
              y_d     = '0;
              z_d     = '0;
              tap_d   = '0;
            end
            ACT_READ: begin
              // in-range check now, data from volume A next cycle
              state_d = ST_READ;
              rd_in_d = 32'(in_px) < 32'(sx) && 32'(in_py) < 32'(sy) &&
                        32'(in_pz) < 32'(sz);
            end
            default: begin
              out_vld_d = 1'b1;
              out_val_d = '0;
              out_usr_d = 2'b00;
            end
          endcase
        end
      end
      ST_READ: begin
        state_d   = ST_IDLE;
        out_vld_d = 1'b1;
        out_val_d = rd_in_q ? a_rd : '0;
        out_usr_d = 2'b01;
      end
      ST_RD: begin
        state_d = (form == FORM_COPY) ? ST_WRITE : ST_MUL;
      end
      ST_MUL: begin
        prod_d  = $signed(vol_rd) * tap_w;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = ((tap_q == 2'd0) ? '0 : acc_q) + ACC_W'(rnd_q16(prod_q));
        if (tap_q == 2'd2) begin
          state_d = ST_WRITE;
        end else begin
          tap_d   = tap_q + 2'd1;
          state_d = ST_RD;
        end
      end
      ST_WRITE: begin
        // advance x fastest, then y, z, then the pass
        tap_d   = '0;
        state_d = ST_RD;
        if (x_q != sx - PW'(1)) begin
          x_d = x_q + PW'(1);
        end else begin
          x_d = '0;
          if (y_q != sy - PW'(1)) begin
            y_d = y_q + PW'(1);
          end else begin
            y_d = '0;
            if (z_q != sz - PW'(1)) begin
              z_d = z_q + PW'(1);
            end else begin
              z_d = '0;
              case (pass_q)
                AXIS_X: pass_d = AXIS_Y;
                AXIS_Y: pass_d = AXIS_Z;
                default: begin
                  pass_d    = AXIS_X;
                  state_d   = ST_IDLE;
                  out_vld_d = 1'b1;
                  out_val_d = '0;
                  out_usr_d = 2'b10;
                end
              endcase
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_usr_q;

endmodule

// ===== hw/rtl/stvf_checker.sv =====
module stvf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // hold a stalled response
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("response dropped while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("read and run flags both set");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 32'd0)
    else $error("nonzero value on a non-read response");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while one is in flight");

endmodule

bind separable_three_tap_volume_filter stvf_checker u_stvf_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid_i,
  .s_axis_tready_o,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o,
  .m_axis_tuser_o
);
